### rtl/tlia_pkg.sv
// ----------------------------------------------------------------------------
// tlia_pkg: shared definitions for the two-level interrupt aggregator
// Function codes, register offsets, reserved-bit table and group control types.
// ----------------------------------------------------------------------------
package tlia_pkg;

   localparam int NUM_GROUPS_DEFAULT = 5;
   localparam int MAX_GROUPS         = 8;
   localparam int GROUP_BITS         = 32;
   localparam int REGS_PER_BLOCK     = 5;

   // Function codes of a request word.
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_PIN   = 2'd2;

   // Register offsets inside a group block or the top-level block.
   localparam logic [2:0] REG_STATUS  = 3'd0;
   localparam logic [2:0] REG_MASK    = 3'd1;
   localparam logic [2:0] REG_ENABLE  = 3'd2;
   localparam logic [2:0] REG_DISABLE = 3'd3;
   localparam logic [2:0] REG_TRIGGER = 3'd4;

   // Word offset of the top-level block.
   localparam logic [5:0] TOP_BASE = 6'd40;

   // Write data bits that a group ignores.
   localparam logic [31:0] RSVD_BITS [MAX_GROUPS] = '{
      32'h0000_00ff, 32'h0000_0000, 32'h0000_0000, 32'h0000_00ff,
      32'hf000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
   };

   // One cycle's worth of work for a single group.
   typedef struct packed {
      logic       status_wr;
      logic       enable_wr;
      logic       disable_wr;
      logic       trigger_wr;
      logic       pin_wr;
      logic [4:0] pin_bit;
      logic       pin_level;
   } group_op_type;

   // What a group reports back toward the top-level status.
   typedef struct packed {
      logic refresh;
      logic pending;
   } group_flag_type;

endpackage

### rtl/tlia_group.sv
// ----------------------------------------------------------------------------
// tlia_group: one group of 32 interrupt pins
// Holds sticky status, mask and pin levels, and reports its pending state.
// ----------------------------------------------------------------------------
module tlia_group
   import tlia_pkg::*;
#(
   parameter int GROUP_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  group_op_type          op,
   input  logic [GROUP_BITS-1:0] write_data,
   output logic [GROUP_BITS-1:0] status,
   output logic [GROUP_BITS-1:0] mask,
   output group_flag_type        flag
);

   logic [GROUP_BITS-1:0] status_ff, status_in;
   logic [GROUP_BITS-1:0] mask_ff, mask_in;
   logic [GROUP_BITS-1:0] pins_ff, pins_in;
   logic [GROUP_BITS-1:0] wr_bits;

   assign wr_bits = write_data & ~RSVD_BITS[GROUP_IDX];

   always_comb begin
      pins_in   = pins_ff;
      status_in = status_ff;
      mask_in   = mask_ff;
      if (op.pin_wr) begin
         pins_in[op.pin_bit] = op.pin_level;
         status_in = status_ff | pins_in;
      end
      if (op.status_wr) begin
         status_in = (status_ff & ~wr_bits) | pins_ff;
      end
      if (op.trigger_wr) begin
         status_in = status_ff | wr_bits;
      end
      if (op.enable_wr) begin
         mask_in = mask_ff & ~wr_bits;
      end
      if (op.disable_wr) begin
         mask_in = mask_ff | wr_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         mask_ff   <= '1;
         pins_ff   <= '0;
      end else begin
         status_ff <= status_in;
         mask_ff   <= mask_in;
         pins_ff   <= pins_in;
      end
   end

   assign status       = status_ff;
   assign mask         = mask_ff;
   assign flag.pending = |(status_in & ~mask_in);
   assign flag.refresh = op.status_wr | op.enable_wr | op.disable_wr |
                         op.trigger_wr | op.pin_wr;

endmodule

### rtl/two_level_interrupt_aggregator.sv
// ----------------------------------------------------------------------------
// two_level_interrupt_aggregator: grouped interrupt status and mask block
// Register-mapped aggregator of up to 256 pins into one interrupt output.
// ----------------------------------------------------------------------------
// Every request word (a bus read, a bus write or a pin level change) yields
// exactly one response word carrying the read data (zero unless the word was
// a read) and the interrupt level after the word took effect. The block takes
// one word per cycle unless stalled: a word is captured in an input register,
// and once the response register is free, its register update and its
// response are computed by one pass of logic over the group and top-level
// registers and land in the response register. The request side keeps
// accepting while a response waits, and only stalls while both the input
// register and the response register are full and the response is held.
// Group n answers at word offsets 5n..5n+4 (status, mask, enable, disable,
// trigger), the top level at 40..44 in the same order. Status is
// write-one-to-clear and is refilled from the live pin levels; masks reset to
// all ones, so nothing interrupts until a source is enabled.
// ----------------------------------------------------------------------------
module two_level_interrupt_aggregator
   import tlia_pkg::*;
#(
   parameter int NUM_GROUPS = NUM_GROUPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_word_addr,
   input  logic [31:0] req_write_data,
   input  logic [7:0]  req_pin_index,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_level
);

   // Input register. It holds one word until the response register is free.
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  func_ff;
   logic [5:0]  addr_ff;
   logic [31:0] data_ff;
   logic [7:0]  pin_ff;
   logic        level_ff;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff;
   logic        rsp_irq_level_ff;

   // Top-level status and mask, one bit per group.
   logic [NUM_GROUPS-1:0] top_status_ff, top_status_in;
   logic [NUM_GROUPS-1:0] top_mask_ff, top_mask_in;

   logic req_accept;
   logic advance;

   // A word moves from the input register to the response register whenever
   // the response register is empty or is being emptied in this cycle.
   assign advance     = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = in_valid_ff & ~advance;
   assign req_accept  = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   logic is_read, is_write, is_pin;
   assign is_read  = advance & (func_ff == FUNC_READ);
   assign is_write = advance & (func_ff == FUNC_WRITE);
   assign is_pin   = advance & (func_ff == FUNC_PIN);

   // Per-group decode, state and read contribution.
   logic [GROUP_BITS-1:0] grp_status [NUM_GROUPS];
   logic [GROUP_BITS-1:0] grp_mask   [NUM_GROUPS];
   logic [GROUP_BITS-1:0] grp_rdata  [NUM_GROUPS];
   group_op_type          grp_op     [NUM_GROUPS];
   group_flag_type        grp_flag   [NUM_GROUPS];

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : gen_group
      localparam logic [5:0] BASE = 6'(REGS_PER_BLOCK * g);
      localparam logic [5:0] LAST = 6'(REGS_PER_BLOCK * g + REGS_PER_BLOCK - 1);
      logic       hit;
      logic [5:0] offset;
      logic [2:0] reg_sel;
      logic       pin_hit;

      assign hit     = (addr_ff >= BASE) & (addr_ff <= LAST);
      assign offset  = addr_ff - BASE;
      assign reg_sel = offset[2:0];
      assign pin_hit = is_pin & (pin_ff[7:5] == 3'(g));

      assign grp_op[g].status_wr  = is_write & hit & (reg_sel == REG_STATUS);
      assign grp_op[g].enable_wr  = is_write & hit & (reg_sel == REG_ENABLE);
      assign grp_op[g].disable_wr = is_write & hit & (reg_sel == REG_DISABLE);
      assign grp_op[g].trigger_wr = is_write & hit & (reg_sel == REG_TRIGGER);
      assign grp_op[g].pin_wr     = pin_hit;
      assign grp_op[g].pin_bit    = pin_ff[4:0];
      assign grp_op[g].pin_level  = level_ff;

      // The write-only registers read as zero.
      always_comb begin
         grp_rdata[g] = '0;
         if (hit & (reg_sel == REG_STATUS)) begin
            grp_rdata[g] = grp_status[g];
         end else if (hit & (reg_sel == REG_MASK)) begin
            grp_rdata[g] = grp_mask[g];
         end
      end

      tlia_group #(
         .GROUP_IDX (g)
      ) u_group (
         .clock      (clock),
         .reset      (reset),
         .op         (grp_op[g]),
         .write_data (data_ff),
         .status     (grp_status[g]),
         .mask       (grp_mask[g]),
         .flag       (grp_flag[g])
      );
   end

   // Top-level register decode.
   logic                  top_hit;
   logic [5:0]            top_offset;
   logic [2:0]            top_reg;
   logic [NUM_GROUPS-1:0] top_bits;

   assign top_hit    = (addr_ff >= TOP_BASE) &
                       (addr_ff <= TOP_BASE + 6'(REGS_PER_BLOCK - 1));
   assign top_offset = addr_ff - TOP_BASE;
   assign top_reg    = top_offset[2:0];
   assign top_bits   = data_ff[NUM_GROUPS-1:0];

   // A top status write ignores its data and recomputes every group, which
   // leaves each bit equal to its group's pending state. A top trigger only
   // sets bits; the group overrides it on its next update.
   always_comb begin
      top_status_in = top_status_ff;
      top_mask_in   = top_mask_ff;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (grp_flag[g].refresh) begin
            top_status_in[g] = grp_flag[g].pending;
         end
      end
      if (is_write & top_hit) begin
         case (top_reg)
            REG_STATUS: begin
               for (int g = 0; g < NUM_GROUPS; g++) begin
                  top_status_in[g] = grp_flag[g].pending;
               end
            end
            REG_ENABLE:  top_mask_in   = top_mask_ff & ~top_bits;
            REG_DISABLE: top_mask_in   = top_mask_ff | top_bits;
            REG_TRIGGER: top_status_in = top_status_ff | top_bits;
            default:     top_mask_in   = top_mask_ff;
         endcase
      end
   end

   // Read data, from the state as it stood before this word.
   logic [31:0] read_data;
   always_comb begin
      read_data = '0;
      if (is_read) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            read_data = read_data | grp_rdata[g];
         end
         if (top_hit & (top_reg == REG_STATUS)) begin
            read_data = 32'(top_status_ff);
         end else if (top_hit & (top_reg == REG_MASK)) begin
            read_data = 32'(top_mask_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         top_status_ff <= '0;
         top_mask_ff   <= '1;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         top_status_ff <= top_status_in;
         top_mask_ff   <= top_mask_in;
      end
      if (req_accept) begin
         func_ff  <= req_func;
         addr_ff  <= req_word_addr;
         data_ff  <= req_write_data;
         pin_ff   <= req_pin_index;
         level_ff <= req_pin_level;
      end
      if (advance) begin
         rsp_read_data_ff <= read_data;
         rsp_irq_level_ff <= |(top_status_in & ~top_mask_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_irq_level = rsp_irq_level_ff;

endmodule
